FILE: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Sonar sweep tracker package
// Shared widths, constants, item types and the control store of the
// microcoded sequencer.
// ----------------------------------------------------------------------------
package sst_pkg;

	// Field widths.
	localparam int ANG_W   = 8;
	localparam int DIST_W  = 16;
	localparam int FILT_W  = 13;
	localparam int NEAR_W  = 14;
	localparam int STEPS_W = 16;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 16;

	// Interpolation datapath: signed angle difference times signed step
	// difference gives the dividend of the iterative divider.
	localparam int ADIFF_W = ANG_W + 1;
	localparam int SDIFF_W = STEPS_W + 1;
	localparam int PROD_W  = ADIFF_W + SDIFF_W;
	localparam int CNT_W   = $clog2(PROD_W + 1);

	// Distance gates and smoothing, in 1/16 cm.
	localparam logic [DIST_W-1:0]        DIST_MIN  = 16'd32;
	localparam logic [DIST_W-1:0]        DIST_MAX  = 16'd6400;
	localparam logic signed [DIST_W:0]   JUMP_MAX  = 17'sd1280;
	localparam logic [NEAR_W-1:0]        NO_TARGET = 14'd15984;
	// x / 10 == (x * 52429) >> 19 for every 16-bit x.
	localparam int                       EMA_RECIP_W = 17;
	localparam logic [EMA_RECIP_W-1:0]   EMA_RECIP   = 17'd52429;
	localparam int                       EMA_SHIFT   = 19;

	// Reset values of the tracking state and the registers.
	localparam logic [ANG_W-1:0]          NEAR_ANGLE_RST   = 8'd90;
	localparam logic signed [STEPS_W-1:0] POINTER_RST      = 16'sd1024;
	localparam logic [ANG_W-1:0]          MIN_ANGLE_RST    = 8'd0;
	localparam logic [ANG_W-1:0]          MAX_ANGLE_RST    = 8'd180;
	localparam logic signed [STEPS_W-1:0] STEPS_AT_MIN_RST = 16'sd0;
	localparam logic signed [STEPS_W-1:0] STEPS_AT_MID_RST = 16'sd1024;
	localparam logic signed [STEPS_W-1:0] STEPS_AT_MAX_RST = 16'sd2048;

	// Command modes.
	localparam logic [MODE_W-1:0] MODE_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DIST  = 2'd2;

	// Register indexes.
	localparam logic [IDX_W-1:0] REG_MIN_ANGLE    = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_ANGLE    = 3'd1;
	localparam logic [IDX_W-1:0] REG_STEPS_AT_MIN = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEPS_AT_MID = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEPS_AT_MAX = 3'd4;

	// Datapath operations of a control word.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
	localparam logic [OP_W-1:0] OP_START  = 4'd1;
	localparam logic [OP_W-1:0] OP_SWEEP  = 4'd2;
	localparam logic [OP_W-1:0] OP_SEG    = 4'd3;
	localparam logic [OP_W-1:0] OP_MUL    = 4'd4;
	localparam logic [OP_W-1:0] OP_DINIT  = 4'd5;
	localparam logic [OP_W-1:0] OP_DIV    = 4'd6;
	localparam logic [OP_W-1:0] OP_FINISH = 4'd7;
	localparam logic [OP_W-1:0] OP_GATE   = 4'd8;
	localparam logic [OP_W-1:0] OP_EMA    = 4'd9;
	localparam logic [OP_W-1:0] OP_EMIT   = 4'd10;

	// Sequencing conditions of a control word.
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_NEXT     = 3'd0; // fall through
	localparam logic [COND_W-1:0] C_JUMP     = 3'd1; // unconditional jump
	localparam logic [COND_W-1:0] C_DISPATCH = 3'd2; // wait for an item, branch on mode
	localparam logic [COND_W-1:0] C_NO_TURN  = 3'd3; // jump when no turnaround
	localparam logic [COND_W-1:0] C_DEN_ZERO = 3'd4; // jump when segment is empty
	localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd5; // loop while bits remain
	localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd6; // hold while output full, else idle

	// Program addresses.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] ST_START  = 4'd1;
	localparam logic [STEP_W-1:0] ST_SWEEP  = 4'd2;
	localparam logic [STEP_W-1:0] ST_SEG    = 4'd3;
	localparam logic [STEP_W-1:0] ST_MUL    = 4'd4;
	localparam logic [STEP_W-1:0] ST_DINIT  = 4'd5;
	localparam logic [STEP_W-1:0] ST_DIV    = 4'd6;
	localparam logic [STEP_W-1:0] ST_FINISH = 4'd7;
	localparam logic [STEP_W-1:0] ST_GATE   = 4'd8;
	localparam logic [STEP_W-1:0] ST_EMA    = 4'd9;
	localparam logic [STEP_W-1:0] ST_EMIT   = 4'd10;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [DIST_W-1:0] distance;
	} cmd_t;

	typedef struct packed {
		logic [ANG_W-1:0]          servo_angle;
		logic                      sample_valid;
		logic [FILT_W-1:0]         filtered_distance;
		logic                      new_nearest;
		logic                      pointer_move;
		logic                      move_backward;
		logic [STEPS_W-1:0]        move_steps;
		logic signed [STEPS_W-1:0] pointer_target;
	} result_t;

	// Control store. Each mode runs a short program that ends in the emit step.
	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
		uword_t w;
		case (addr)
			ST_IDLE:   w = '{op: OP_NOP,    cond: C_DISPATCH, target: ST_IDLE};
			ST_START:  w = '{op: OP_START,  cond: C_JUMP,     target: ST_EMIT};
			ST_SWEEP:  w = '{op: OP_SWEEP,  cond: C_NO_TURN,  target: ST_EMIT};
			ST_SEG:    w = '{op: OP_SEG,    cond: C_DEN_ZERO, target: ST_FINISH};
			ST_MUL:    w = '{op: OP_MUL,    cond: C_NEXT,     target: ST_IDLE};
			ST_DINIT:  w = '{op: OP_DINIT,  cond: C_NEXT,     target: ST_IDLE};
			ST_DIV:    w = '{op: OP_DIV,    cond: C_DIV_BUSY, target: ST_DIV};
			ST_FINISH: w = '{op: OP_FINISH, cond: C_JUMP,     target: ST_EMIT};
			ST_GATE:   w = '{op: OP_GATE,   cond: C_NEXT,     target: ST_IDLE};
			ST_EMA:    w = '{op: OP_EMA,    cond: C_NEXT,     target: ST_IDLE};
			ST_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: ST_EMIT};
			default:   w = '{op: OP_NOP,    cond: C_JUMP,     target: ST_IDLE};
		endcase
		return w;
	endfunction

	// Entry point of the program for each mode. An unused mode only emits.
	function automatic logic [STEP_W-1:0] mode_entry(input logic [MODE_W-1:0] mode);
		logic [STEP_W-1:0] s;
		case (mode)
			MODE_START: s = ST_START;
			MODE_READ:  s = ST_SWEEP;
			MODE_DIST:  s = ST_GATE;
			default:    s = ST_EMIT;
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/sst_cmd_if.sv
// ----------------------------------------------------------------------------
// Sonar sweep tracker command channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface sst_cmd_if import sst_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sst_result_if.sv
// ----------------------------------------------------------------------------
// Sonar sweep tracker result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface sst_result_if import sst_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sonar_sweep_nearest_tracker.sv
// ----------------------------------------------------------------------------
// Sonar sweep nearest-target tracker
// Servo sweep generator, sonar distance filter and pointer positioner.
// ----------------------------------------------------------------------------
// The block takes one command item at a time and returns exactly one result
// item for it. A start command (mode 0) runs the start step, a distance
// (mode 2) the gate and smoothing steps, an unused mode only the emit step,
// and a reading command (mode 1) the sweep step; at a turnaround the
// nearest angle is then interpolated to a stepper position (the multiply
// and divide are skipped when the segment of the nearest angle is empty),
// and the division inside that interpolation runs on a restoring divider
// that produces one quotient bit per cycle over a 26-bit
// dividend. The command side is ready only while the sequencer sits in its
// idle step; the finished result sits in an output register, so the next
// command is taken while the previous result still waits to be consumed.
// Configuration registers are written through wr_en/wr_index/wr_data and
// should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module sonar_sweep_nearest_tracker
	import sst_pkg::*;
#(
	parameter int ANGLE_LIMIT = 180,
	parameter int ANGLE_STEP  = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	sst_cmd_if.sink           cmd,
	sst_result_if.source      result,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_index,
	input  logic [CFG_W-1:0]  wr_data
);

	localparam logic [ANG_W-1:0] LIMIT_A = ANG_W'(ANGLE_LIMIT);
	localparam logic [ANG_W:0]   STEP_A  = (ANG_W + 1)'(ANGLE_STEP);
	localparam logic signed [PROD_W+1:0] R_MAX = (PROD_W + 2)'(2 ** (STEPS_W - 1) - 1);
	localparam logic signed [PROD_W+1:0] R_MIN = -(PROD_W + 2)'(2 ** (STEPS_W - 1));

	function automatic logic [ANG_W-1:0] clamp_angle(input logic [ANG_W-1:0] a);
		return (a > LIMIT_A) ? LIMIT_A : a;
	endfunction

	// Configuration registers.
	logic [ANG_W-1:0]          min_angle_q, max_angle_q;
	logic signed [STEPS_W-1:0] steps_min_q, steps_mid_q, steps_max_q;

	// Tracking state.
	logic [ANG_W-1:0]          sweep_q, sampled_q, near_angle_q;
	logic                      down_q, primed_q;
	logic [FILT_W-1:0]         smooth_q;
	logic [NEAR_W-1:0]         near_dist_q;
	logic signed [STEPS_W-1:0] pointer_q;

	// Sequencer.
	logic [STEP_W-1:0] step_q, step_nx;
	logic [CNT_W-1:0]  cnt_q;
	uword_t            uw;

	// Output register.
	logic    out_valid_q;
	result_t out_data_q;

	// Datapath registers.
	logic [DIST_W-1:0]         dist_q;
	result_t                   res_q, res_out;
	logic signed [STEPS_W-1:0] ls_q;
	logic signed [ADIFF_W-1:0] adiff_q;
	logic signed [SDIFF_W-1:0] sdiff_q;
	logic [ANG_W-1:0]          den_mag_q;
	logic                      den_neg_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [PROD_W-1:0]         quo_q;
	logic [ANG_W-1:0]          rem_q;
	logic                      q_neg_q;
	logic [DIST_W-1:0]         sum_q;
	logic                      ok_q, direct_q;

	// Combinational datapath.
	logic                      accept, out_busy, emit_go;
	logic [ANG_W-1:0]          lo, hi, mid;
	logic [ANG_W:0]            mid_sum, up_sum, lo_sum;
	logic [ANG_W-1:0]          sweep_nx;
	logic                      down_nx, turn;
	logic                      lower;
	logic [ANG_W-1:0]          la, ra;
	logic signed [STEPS_W-1:0] ls, rs;
	logic signed [ADIFF_W-1:0] adiff;
	logic signed [SDIFF_W-1:0] sdiff;
	logic signed [ANG_W:0]     den, den_abs;
	logic                      den_zero;
	logic [ANG_W:0]            trial, trial_sub;
	logic                      trial_ge;
	logic signed [PROD_W:0]    q_s;
	logic signed [PROD_W+1:0]  r_sum;
	logic signed [STEPS_W-1:0] target;
	logic signed [STEPS_W:0]   delta, delta_abs;
	logic signed [DIST_W:0]    gdiff;
	logic                      range_ok, jump_bad, gate_ok;
	logic [DIST_W-1:0]         sum_nx;
	logic [DIST_W+EMA_RECIP_W-1:0] ema_prod;
	logic [FILT_W-1:0]         new_f;

	assign uw         = ucode_rom(step_q);
	assign cmd.ready  = (step_q == ST_IDLE);
	assign accept     = cmd.valid && cmd.ready;
	assign out_busy   = out_valid_q && !result.ready;
	assign emit_go    = (uw.op == OP_EMIT) && !out_busy;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	always_comb begin
		// Clamped sweep limits; the midpoint comes from the raw registers.
		lo      = clamp_angle(min_angle_q);
		hi      = clamp_angle(max_angle_q);
		mid_sum = {1'b0, min_angle_q} + {1'b0, max_angle_q};
		mid     = clamp_angle(mid_sum[ANG_W:1]);

		// Sweep advance and turnaround detection.
		up_sum = {1'b0, sweep_q} + STEP_A;
		lo_sum = {1'b0, lo} + STEP_A;
		if (!down_q) begin
			turn     = (up_sum >= {1'b0, hi});
			sweep_nx = turn ? hi : up_sum[ANG_W-1:0];
			down_nx  = turn;
		end else begin
			turn     = ({1'b0, sweep_q} <= lo_sum);
			sweep_nx = turn ? lo : (sweep_q - STEP_A[ANG_W-1:0]);
			down_nx  = !turn;
		end

		// Segment selection for the interpolation of the nearest angle.
		lower    = (near_angle_q <= mid);
		la       = lower ? lo : mid;
		ra       = lower ? mid : hi;
		ls       = lower ? steps_min_q : steps_mid_q;
		rs       = lower ? steps_mid_q : steps_max_q;
		adiff    = $signed({1'b0, near_angle_q}) - $signed({1'b0, la});
		sdiff    = rs - ls;
		den      = $signed({1'b0, ra}) - $signed({1'b0, la});
		den_abs  = den[ANG_W] ? -den : den;
		den_zero = (ra == la);

		// One restoring division step on magnitudes.
		trial     = {rem_q, quo_q[PROD_W-1]};
		trial_ge  = (trial >= {1'b0, den_mag_q});
		trial_sub = trial - {1'b0, den_mag_q};

		// Signed quotient, offset by the left step value, saturated.
		q_s   = q_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		r_sum = ls_q + q_s;
		if (r_sum > R_MAX) begin
			target = R_MAX[STEPS_W-1:0];
		end else if (r_sum < R_MIN) begin
			target = R_MIN[STEPS_W-1:0];
		end else begin
			target = r_sum[STEPS_W-1:0];
		end
		delta     = target - pointer_q;
		delta_abs = delta[STEPS_W] ? -delta : delta;

		// Distance gates and smoothing.
		range_ok = (dist_q >= DIST_MIN) && (dist_q <= DIST_MAX);
		gdiff    = $signed({1'b0, dist_q})
			- $signed({{(DIST_W - FILT_W + 1){1'b0}}, smooth_q});
		jump_bad = (gdiff > JUMP_MAX) || (gdiff < -JUMP_MAX);
		gate_ok  = range_ok && !(primed_q && jump_bad);
		sum_nx   = ({{(DIST_W - FILT_W){1'b0}}, smooth_q} * DIST_W'(7))
			+ (dist_q * DIST_W'(3));
		ema_prod = sum_q * EMA_RECIP;
		new_f    = direct_q ? dist_q[FILT_W-1:0] : ema_prod[EMA_SHIFT +: FILT_W];

		res_out = res_q;
		res_out.pointer_target = pointer_q;
	end

	// Next program address.
	always_comb begin
		case (uw.cond)
			C_NEXT:     step_nx = step_q + 1'b1;
			C_JUMP:     step_nx = uw.target;
			C_DISPATCH: step_nx = accept ? mode_entry(cmd.data.mode) : step_q;
			C_NO_TURN:  step_nx = turn ? (step_q + 1'b1) : uw.target;
			C_DEN_ZERO: step_nx = den_zero ? uw.target : (step_q + 1'b1);
			C_DIV_BUSY: step_nx = (cnt_q != CNT_W'(1)) ? uw.target : (step_q + 1'b1);
			C_OUT_BUSY: step_nx = out_busy ? uw.target : ST_IDLE;
			default:    step_nx = ST_IDLE;
		endcase
	end

	// Control and tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_angle_q  <= MIN_ANGLE_RST;
			max_angle_q  <= MAX_ANGLE_RST;
			steps_min_q  <= STEPS_AT_MIN_RST;
			steps_mid_q  <= STEPS_AT_MID_RST;
			steps_max_q  <= STEPS_AT_MAX_RST;
			sweep_q      <= '0;
			sampled_q    <= '0;
			down_q       <= 1'b0;
			smooth_q     <= '0;
			primed_q     <= 1'b0;
			near_dist_q  <= NO_TARGET;
			near_angle_q <= NEAR_ANGLE_RST;
			pointer_q    <= POINTER_RST;
			step_q       <= ST_IDLE;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			step_q <= step_nx;

			if (wr_en) begin
				case (wr_index)
					REG_MIN_ANGLE:    min_angle_q <= wr_data[ANG_W-1:0];
					REG_MAX_ANGLE:    max_angle_q <= wr_data[ANG_W-1:0];
					REG_STEPS_AT_MIN: steps_min_q <= $signed(wr_data[STEPS_W-1:0]);
					REG_STEPS_AT_MID: steps_mid_q <= $signed(wr_data[STEPS_W-1:0]);
					REG_STEPS_AT_MAX: steps_max_q <= $signed(wr_data[STEPS_W-1:0]);
					default: ;
				endcase
			end

			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			case (uw.op)
				OP_START: begin
					sweep_q      <= lo;
					sampled_q    <= lo;
					down_q       <= 1'b0;
					smooth_q     <= '0;
					primed_q     <= 1'b0;
					near_dist_q  <= NO_TARGET;
					near_angle_q <= lo;
				end
				OP_SWEEP: begin
					sampled_q <= sweep_q;
					sweep_q   <= sweep_nx;
					down_q    <= down_nx;
				end
				OP_DINIT: begin
					cnt_q <= CNT_W'(PROD_W);
				end
				OP_DIV: begin
					cnt_q <= cnt_q - 1'b1;
				end
				OP_FINISH: begin
					pointer_q   <= target;
					near_dist_q <= NO_TARGET;
				end
				OP_EMA: begin
					if (ok_q) begin
						smooth_q <= new_f;
						primed_q <= 1'b1;
						if ({1'b0, new_f} < near_dist_q) begin
							near_dist_q  <= {1'b0, new_f};
							near_angle_q <= sampled_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers and the result being built.
	always_ff @(posedge clk) begin
		if (accept) begin
			dist_q <= cmd.data.distance;
			res_q  <= '0;
		end

		case (uw.op)
			OP_START: begin
				res_q.servo_angle <= lo;
			end
			OP_SWEEP: begin
				res_q.servo_angle <= sweep_q;
			end
			OP_SEG: begin
				ls_q      <= ls;
				adiff_q   <= adiff;
				sdiff_q   <= sdiff;
				den_mag_q <= den_abs[ANG_W-1:0];
				den_neg_q <= den[ANG_W];
				quo_q     <= '0;
				q_neg_q   <= 1'b0;
			end
			OP_MUL: begin
				prod_q <= adiff_q * sdiff_q;
			end
			OP_DINIT: begin
				quo_q   <= prod_q[PROD_W-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
				rem_q   <= '0;
				q_neg_q <= prod_q[PROD_W-1] ^ den_neg_q;
			end
			OP_DIV: begin
				rem_q <= trial_ge ? trial_sub[ANG_W-1:0] : trial[ANG_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], trial_ge};
			end
			OP_FINISH: begin
				res_q.pointer_move  <= (delta != '0);
				res_q.move_backward <= delta[STEPS_W];
				res_q.move_steps    <= delta_abs[STEPS_W-1:0];
			end
			OP_GATE: begin
				res_q.servo_angle <= sampled_q;
				ok_q              <= gate_ok;
				direct_q          <= !primed_q;
				sum_q             <= sum_nx;
			end
			OP_EMA: begin
				if (ok_q) begin
					res_q.sample_valid      <= 1'b1;
					res_q.filtered_distance <= new_f;
					res_q.new_nearest       <= ({1'b0, new_f} < near_dist_q);
				end
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_data_q <= res_out;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/sonar_sweep_nearest_tracker_test.sv
// ----------------------------------------------------------------------------
// Sonar sweep nearest-target tracker testbench
// Drives command items into the tracker under random idling on both
// channels. A scoreboard predicts every result item: sweep angle and
// direction, distance gating and smoothing, the nearest record of each sweep,
// and the interpolated pointer move at each turnaround. Each result is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
import sst_pkg::*;

// Holds its own copy of the tracker state and the calibration registers. A
// command is turned into its predicted result when the block accepts it,
// and results are checked in order as the block hands them out.
class tracker_scoreboard;
	int angle_limit;
	int angle_step;

	// Calibration registers.
	logic [ANG_W-1:0]          cfg_min_angle;
	logic [ANG_W-1:0]          cfg_max_angle;
	logic signed [STEPS_W-1:0] cal_min;
	logic signed [STEPS_W-1:0] cal_mid;
	logic signed [STEPS_W-1:0] cal_max;

	// Tracking state.
	logic [ANG_W-1:0]          cur_angle;
	logic [ANG_W-1:0]          latched_angle;
	bit                        heading_down;
	logic [FILT_W-1:0]         ema_value;
	bit                        ema_loaded;
	logic [NEAR_W-1:0]         best_dist;
	logic [ANG_W-1:0]          best_angle;
	logic signed [STEPS_W-1:0] pointer_pos;

	result_t pending_results[$];
	int      error_count;

	function new(int limit, int step);
		angle_limit   = limit;
		angle_step    = step;
		cfg_min_angle = MIN_ANGLE_RST;
		cfg_max_angle = MAX_ANGLE_RST;
		cal_min       = STEPS_AT_MIN_RST;
		cal_mid       = STEPS_AT_MID_RST;
		cal_max       = STEPS_AT_MAX_RST;
		cur_angle     = '0;
		latched_angle = '0;
		heading_down  = 1'b0;
		ema_value     = '0;
		ema_loaded    = 1'b0;
		best_dist     = NO_TARGET;
		best_angle    = NEAR_ANGLE_RST;
		pointer_pos   = POINTER_RST;
		error_count   = 0;
	endfunction

	function void set_register(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
		case (index)
			REG_MIN_ANGLE:    cfg_min_angle = value[ANG_W-1:0];
			REG_MAX_ANGLE:    cfg_max_angle = value[ANG_W-1:0];
			REG_STEPS_AT_MIN: cal_min = value;
			REG_STEPS_AT_MID: cal_mid = value;
			REG_STEPS_AT_MAX: cal_max = value;
			default: ;
		endcase
	endfunction

	function int clamp_to_limit(int a);
		return (a > angle_limit) ? angle_limit : a;
	endfunction

	// Piecewise-linear map from an angle to a stepper position through the
	// lower, middle and upper calibration points, saturated to 16 bits.
	function int stepper_target(logic [ANG_W-1:0] angle);
		longint a, mid, la, ra, ls, rs, pos;
		a   = angle;
		mid = clamp_to_limit((int'(cfg_min_angle) + int'(cfg_max_angle)) / 2);
		if (a <= mid) begin
			la = clamp_to_limit(cfg_min_angle);
			ls = cal_min;
			ra = mid;
			rs = cal_mid;
		end else begin
			la = mid;
			ls = cal_mid;
			ra = clamp_to_limit(cfg_max_angle);
			rs = cal_max;
		end
		// An empty segment keeps its left calibration value.
		pos = (ra == la) ? ls : ls + (a - la) * (rs - ls) / (ra - la);
		if (pos > 32767)
			pos = 32767;
		if (pos < -32768)
			pos = -32768;
		return int'(pos);
	endfunction

	function result_t tracker_response(cmd_t c);
		result_t r;
		int      lo, hi, d, diff, target, delta;
		bit      turn, pass;
		r  = '0;
		lo = clamp_to_limit(cfg_min_angle);
		hi = clamp_to_limit(cfg_max_angle);
		case (c.mode)
			MODE_START: begin
				cur_angle     = ANG_W'(lo);
				latched_angle = ANG_W'(lo);
				heading_down  = 1'b0;
				ema_value     = '0;
				ema_loaded    = 1'b0;
				best_dist     = NO_TARGET;
				best_angle    = ANG_W'(lo);
				r.servo_angle = ANG_W'(lo);
			end
			MODE_READ: begin
				r.servo_angle = cur_angle;
				latched_angle = cur_angle;
				turn = 1'b0;
				if (!heading_down) begin
					if (int'(cur_angle) + angle_step >= hi) begin
						cur_angle    = ANG_W'(hi);
						heading_down = 1'b1;
						turn         = 1'b1;
					end else begin
						cur_angle = ANG_W'(int'(cur_angle) + angle_step);
					end
				end else begin
					if (int'(cur_angle) <= lo + angle_step) begin
						cur_angle    = ANG_W'(lo);
						heading_down = 1'b0;
						turn         = 1'b1;
					end else begin
						cur_angle = ANG_W'(int'(cur_angle) - angle_step);
					end
				end
				if (turn) begin
					target = stepper_target(best_angle);
					delta  = target - int'(pointer_pos);
					if (delta != 0) begin
						r.pointer_move  = 1'b1;
						r.move_backward = (delta < 0);
						r.move_steps    = STEPS_W'((delta < 0) ? -delta : delta);
					end
					pointer_pos = STEPS_W'(target);
					best_dist   = NO_TARGET;
				end
			end
			MODE_DIST: begin
				d = c.distance;
				r.servo_angle = latched_angle;
				pass = (d >= DIST_MIN) && (d <= DIST_MAX);
				if (pass && ema_loaded) begin
					diff = d - int'(ema_value);
					if (diff > JUMP_MAX || diff < -JUMP_MAX)
						pass = 1'b0;
				end
				if (pass) begin
					if (!ema_loaded) begin
						ema_value  = FILT_W'(d);
						ema_loaded = 1'b1;
					end else begin
						ema_value = FILT_W'((7 * int'(ema_value) + 3 * d) / 10);
					end
					r.sample_valid      = 1'b1;
					r.filtered_distance = ema_value;
					if (ema_value < best_dist) begin
						best_dist     = ema_value;
						best_angle    = latched_angle;
						r.new_nearest = 1'b1;
					end
				end
			end
			// The unused mode changes nothing and reports angle zero.
			default: ;
		endcase
		r.pointer_target = pointer_pos;
		return r;
	endfunction

	function void note_command(cmd_t c);
		pending_results.push_back(tracker_response(c));
	endfunction

	function void compare_field(string field, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			error_count++;
		end
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: result item with no command outstanding, actual %h", $time, got);
			error_count++;
			return;
		end
		want = pending_results.pop_front();
		compare_field("servo_angle", want.servo_angle, got.servo_angle);
		compare_field("sample_valid", want.sample_valid, got.sample_valid);
		compare_field("filtered_distance", want.filtered_distance, got.filtered_distance);
		compare_field("new_nearest", want.new_nearest, got.new_nearest);
		compare_field("pointer_move", want.pointer_move, got.pointer_move);
		compare_field("move_backward", want.move_backward, got.move_backward);
		compare_field("move_steps", want.move_steps, got.move_steps);
		compare_field("pointer_target", want.pointer_target, got.pointer_target);
	endfunction
endclass

module sonar_sweep_nearest_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SWEEP_LIMIT  = 180;
	localparam int SWEEP_STEP   = 5;
	// Mode 3 has no meaning in the block; it must be ignored.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	// Long stall of the result side, used once to back the block up.
	localparam int HOLD_CYCLES  = 300;
	// Extra wait at the end of the run; this covers any straggler.
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASES       = 12;
	localparam int PHASE_ITEMS  = 85;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	sst_cmd_if    cmd();
	sst_result_if result();

	sonar_sweep_nearest_tracker #(
		.ANGLE_LIMIT(SWEEP_LIMIT),
		.ANGLE_STEP(SWEEP_STEP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	tracker_scoreboard board = new(SWEEP_LIMIT, SWEEP_STEP);

	// Set by the stimulus to make the result side stall for a long stretch.
	bit hold_output;
	// The command side skips its random gaps while this is set.
	bit sender_quiet;
	int sent_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on the run: far beyond the slowest legal run of this
	// stimulus, including the long stall.
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// Offers one command item after a random gap and waits until the block
	// takes it. Valid is only lowered when a gap follows, so a back-to-back
	// item never sees valid dropped and raised in the same step.
	task automatic send_command(input logic [MODE_W-1:0] mode, input logic [DIST_W-1:0] distance);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data  <= '{mode: mode, distance: distance};
		do @(posedge clk); while (!cmd.ready);
		board.note_command(cmd.data);
		sent_count++;
		// Switch between idling and flat-out stretches now and then.
		if (sent_count % 48 == 0)
			sender_quiet = ($urandom_range(0, 3) == 0);
	endtask

	// Stops offering and waits until every predicted result has come back,
	// which leaves the block idle because each command yields one result.
	task automatic settle();
		cmd.valid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] value);
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= value;
		@(posedge clk);
		board.set_register(index, value);
	endtask

	// Writes all five calibration registers back to back.
	task automatic load_setting(input int lo, input int hi, input int s_min, input int s_mid,
			input int s_max);
		write_register(REG_MIN_ANGLE, CFG_W'(lo));
		write_register(REG_MAX_ANGLE, CFG_W'(hi));
		write_register(REG_STEPS_AT_MIN, CFG_W'(s_min));
		write_register(REG_STEPS_AT_MID, CFG_W'(s_mid));
		write_register(REG_STEPS_AT_MAX, CFG_W'(s_max));
		wr_en <= 1'b0;
	endtask

	function automatic int any_steps();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// One phase of random traffic. Most items form proper sweeps: readings
	// that advance the servo, followed by distances that wander slowly so
	// they pass the jump gate and feed the smoother. The rest are scan
	// restarts, the ignored mode, and distances that hit the gates.
	task automatic run_sweep_phase(input int budget, input bit open_with_start);
		int issued, pick, echo, d;
		issued = 0;
		echo   = $urandom_range(200, 6000);
		if (open_with_start) begin
			send_command(MODE_START, DIST_W'($urandom));
			issued = 1;
		end
		while (issued < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				echo = $urandom_range(200, 6000);
				send_command(MODE_START, DIST_W'($urandom));
				issued++;
			end else if (pick < 5) begin
				// Ignored items do not count toward the budget.
				send_command(MODE_UNUSED, DIST_W'($urandom));
			end else if (pick < 47) begin
				send_command(MODE_READ, DIST_W'($urandom));
				issued++;
			end else if (pick < 90) begin
				echo = echo + int'($urandom_range(0, 240)) - 120;
				if (echo < int'(DIST_MIN))
					echo = DIST_MIN;
				if (echo > int'(DIST_MAX))
					echo = DIST_MAX;
				send_command(MODE_DIST, DIST_W'(echo));
				issued++;
			end else begin
				case ($urandom_range(0, 4))
					0: d = $urandom_range(0, 65535);
					1: d = $urandom_range(0, int'(DIST_MIN) - 1);
					2: d = $urandom_range(int'(DIST_MAX) + 1, 65535);
					3: d = echo + 1281 + int'($urandom_range(0, 200));
					default: d = $urandom_range(0, 1) ? DIST_MIN : DIST_MAX;
				endcase
				send_command(MODE_DIST, DIST_W'(d));
				issued++;
			end
		end
		settle();
	endtask

	// Result side: random stalls before each item, flat-out stretches, and
	// once a long hold while the command side keeps offering.
	initial begin : result_sink
		int stall;
		int taken;
		bit ready_quiet;
		taken       = 0;
		ready_quiet = 1'b0;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_output) begin
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				stall = ready_quiet ? 0 : $urandom_range(0, 15);
				if (stall > 0) begin
					result.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			board.check_result(result.data);
			taken++;
			if (taken % 40 == 0)
				ready_quiet = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : stimulus
		int phase, lo, hi;
		hold_output  = 1'b0;
		sender_quiet = 1'b0;
		sent_count   = 0;
		arst_n    <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.data  <= '0;
		wr_en     <= 1'b0;
		wr_index  <= '0;
		wr_data   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration. The first distance arrives before any scan
		// start and is taken against the reset state; the ignored mode
		// follows with every distance bit set.
		send_command(MODE_DIST, 16'd100);
		send_command(MODE_UNUSED, 16'hFFFF);
		send_command(MODE_START, 16'h0000);
		// Distances just outside the accepted window, and the field extremes.
		send_command(MODE_DIST, DIST_MIN - 16'd1);
		send_command(MODE_DIST, DIST_MAX + 16'd1);
		send_command(MODE_DIST, 16'h0000);
		send_command(MODE_DIST, 16'hFFFF);
		// The largest distance loads the smoother, a drop of exactly the jump
		// limit passes, and one step beyond the limit is rejected.
		send_command(MODE_DIST, DIST_MAX);
		send_command(MODE_DIST, DIST_MAX - 16'd1280);
		send_command(MODE_DIST, 16'd4735);
		// Fresh scan: the smallest distance loads, a rise of exactly the jump
		// limit passes.
		send_command(MODE_START, 16'h5555);
		send_command(MODE_DIST, DIST_MIN);
		send_command(MODE_DIST, DIST_MIN + 16'd1280);
		send_command(MODE_READ, 16'hAAAA);
		send_command(MODE_READ, 16'h0000);
		settle();

		// A narrow sweep with extreme calibration: both turnarounds come
		// quickly. The first moves the pointer to the bottom of the stepper
		// range, the second lands on the same target and moves nothing.
		load_setting(90, 100, -32768, 0, 32767);
		send_command(MODE_START, 16'h0000);
		send_command(MODE_DIST, 16'd800);
		send_command(MODE_READ, 16'h0000);
		send_command(MODE_DIST, 16'd700);
		send_command(MODE_READ, 16'h0000);
		send_command(MODE_READ, 16'h0000);
		send_command(MODE_READ, 16'h0000);
		settle();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: load_setting(0, 180, 0, 1024, 2048);
				1: load_setting(0, 180, -32768, 0, 32767);
				// Reversed limits; the mirrored formula drives the target past
				// the 16-bit range so it saturates.
				2: load_setting(150, 30, 0, 32767, -32768);
				// Equal limits leave empty segments.
				3: load_setting(60, 60, any_steps(), any_steps(), any_steps());
				// Both limits above the angle limit get clamped.
				4: load_setting(200, 255, any_steps(), any_steps(), any_steps());
				5: load_setting(0, 255, 32767, -32768, 0);
				default: begin
					lo = $urandom_range(0, 180);
					if ($urandom_range(0, 2) == 0)
						hi = $urandom_range(0, 255);
					else
						hi = lo + int'($urandom_range(0, 40));
					if (hi > 255)
						hi = 255;
					load_setting(lo, hi, any_steps(), any_steps(), any_steps());
				end
			endcase
			// The first phase backs the block up behind a stalled result side.
			if (phase == 0)
				hold_output = 1'b1;
			// One phase keeps the sweep state of the last one under a new
			// setting, so angles outside the limits reach the interpolation.
			run_sweep_phase(PHASE_ITEMS, phase != 7);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.error_count == 0 && board.pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
